[hw/rtl/mpr_pkg.sv]
// Shared types and constants for the motor PWM ramp profile block.
`timescale 1ns / 1ps

package mpr_pkg;

  localparam int DefaultLevelWidth = 8;
  localparam int DefaultTimerWidth = 12;
  localparam int CfgIndexWidth     = 3;

  // Reset values of the configuration registers
  localparam int UpStepReset        = 5;
  localparam int MaxLevelReset      = 255;
  localparam int DownStepReset      = 1;
  localparam int LowLevelReset      = 150;
  localparam int BrakeStepReset     = 3;
  localparam int FullHoldTicksReset = 800;
  localparam int LowHoldTicksReset  = 200;
  localparam int RestTicksReset     = 2500;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhRampUp   = 3'd1,
    PhFull     = 3'd2,
    PhRampDown = 3'd3,
    PhLow      = 3'd4,
    PhBrake    = 3'd5,
    PhRest     = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdDown  = 2'd1,
    CmdUp    = 2'd2,
    CmdCycle = 2'd3
  } cmd_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgUpStep        = 3'd0,
    CfgMaxLevel      = 3'd1,
    CfgDownStep      = 3'd2,
    CfgLowLevel      = 3'd3,
    CfgBrakeStep     = 3'd4,
    CfgFullHoldTicks = 3'd5,
    CfgLowHoldTicks  = 3'd6,
    CfgRestTicks     = 3'd7
  } cfg_index_e;

endpackage

[hw/rtl/motor_pwm_ramp_profile.sv]
// Top level of the trapezoidal motor PWM ramp profile generator.
`timescale 1ns / 1ps

// One input beat is one control tick and yields exactly one result beat, registered, in the
// cycle after acceptance. A tick can be accepted in every cycle: the next profile state
// (phase, level, tick counter, direction, cycle flag) is computed combinationally through
// short compare and add or subtract logic. The input is ready whenever the result
// register is empty or its beat is taken in the same cycle, so ticks flow back to back
// while the output is ready; a result held off by the receiver stalls the input until it
// is taken. Configuration writes are always taken (cfg_ready_o is high) and must only be
// issued while no tick is in flight. There is no clearing pass after reset.
module motor_pwm_ramp_profile #(
  parameter int LEVEL_WIDTH = mpr_pkg::DefaultLevelWidth,
  parameter int TIMER_WIDTH = mpr_pkg::DefaultTimerWidth,
  parameter int CFG_WIDTH   = (LEVEL_WIDTH > TIMER_WIDTH) ? LEVEL_WIDTH : TIMER_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        start_cmd_i,
  input  logic                              lower_limit_pressed_i,
  input  logic                              upper_limit_pressed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [LEVEL_WIDTH-1:0]            drive_level_o,
  output logic                              direction_up_o,
  output logic                              busy_res_o,
  output logic [2:0]                        phase_o,
  output logic                              limit_stop_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mpr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]              cfg_data_i
);
  import mpr_pkg::*;

  logic [LEVEL_WIDTH-1:0] up_step_q, max_level_q, down_step_q, low_level_q, brake_step_q;
  logic [TIMER_WIDTH-1:0] full_hold_q, low_hold_q, rest_q;

  phase_e                 phase_q, phase_d;
  logic [LEVEL_WIDTH-1:0] level_q, level_d;
  logic [TIMER_WIDTH-1:0] tick_q, tick_d;
  logic                   dir_q, dir_d;
  logic                   cycle_q, cycle_d;
  logic                   limit_d;

  logic                   out_valid_q;
  logic [LEVEL_WIDTH-1:0] res_level_q;
  logic                   res_dir_q;
  phase_e                 res_phase_q;
  logic                   res_limit_q;

  logic                   in_fire;
  logic                   cfg_fire;
  cfg_index_e             cfg_sel;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_sel     = cfg_index_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_step_q    <= LEVEL_WIDTH'(UpStepReset);
      max_level_q  <= LEVEL_WIDTH'(MaxLevelReset);
      down_step_q  <= LEVEL_WIDTH'(DownStepReset);
      low_level_q  <= LEVEL_WIDTH'(LowLevelReset);
      brake_step_q <= LEVEL_WIDTH'(BrakeStepReset);
      full_hold_q  <= TIMER_WIDTH'(FullHoldTicksReset);
      low_hold_q   <= TIMER_WIDTH'(LowHoldTicksReset);
      rest_q       <= TIMER_WIDTH'(RestTicksReset);
    end else if (cfg_fire) begin
      case (cfg_sel)
        CfgUpStep:        up_step_q    <= cfg_data_i[LEVEL_WIDTH-1:0];
        CfgMaxLevel:      max_level_q  <= cfg_data_i[LEVEL_WIDTH-1:0];
        CfgDownStep:      down_step_q  <= cfg_data_i[LEVEL_WIDTH-1:0];
        CfgLowLevel:      low_level_q  <= cfg_data_i[LEVEL_WIDTH-1:0];
        CfgBrakeStep:     brake_step_q <= cfg_data_i[LEVEL_WIDTH-1:0];
        CfgFullHoldTicks: full_hold_q  <= cfg_data_i[TIMER_WIDTH-1:0];
        CfgLowHoldTicks:  low_hold_q   <= cfg_data_i[TIMER_WIDTH-1:0];
        CfgRestTicks:     rest_q       <= cfg_data_i[TIMER_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  mpr_step #(
    .LEVEL_WIDTH(LEVEL_WIDTH),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .phase_i              (phase_q),
    .level_i              (level_q),
    .tick_i               (tick_q),
    .dir_i                (dir_q),
    .cycle_i              (cycle_q),
    .start_cmd_i          (start_cmd_i),
    .lower_limit_pressed_i(lower_limit_pressed_i),
    .upper_limit_pressed_i(upper_limit_pressed_i),
    .up_step_i            (up_step_q),
    .max_level_i          (max_level_q),
    .down_step_i          (down_step_q),
    .low_level_i          (low_level_q),
    .brake_step_i         (brake_step_q),
    .full_hold_ticks_i    (full_hold_q),
    .low_hold_ticks_i     (low_hold_q),
    .rest_ticks_i         (rest_q),
    .phase_o              (phase_d),
    .level_o              (level_d),
    .tick_o               (tick_d),
    .dir_o                (dir_d),
    .cycle_o              (cycle_d),
    .limit_o              (limit_d)
  );

  // Advance the profile state once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      level_q <= '0;
      tick_q  <= '0;
      dir_q   <= 1'b0;
      cycle_q <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      level_q <= level_d;
      tick_q  <= tick_d;
      dir_q   <= dir_d;
      cycle_q <= cycle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold until the beat is taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_level_q <= level_d;
      res_dir_q   <= dir_d;
      res_phase_q <= phase_d;
      res_limit_q <= limit_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_level_o  = res_level_q;
  assign direction_up_o = res_dir_q;
  assign busy_res_o     = (res_phase_q != PhIdle);
  assign phase_o        = res_phase_q;
  assign limit_stop_o   = res_limit_q;

endmodule

[hw/rtl/mpr_step.sv]
// Next-state logic of the ramp profile for one tick.
`timescale 1ns / 1ps

module mpr_step #(
  parameter int LEVEL_WIDTH = mpr_pkg::DefaultLevelWidth,
  parameter int TIMER_WIDTH = mpr_pkg::DefaultTimerWidth
) (
  input  mpr_pkg::phase_e         phase_i,
  input  logic [LEVEL_WIDTH-1:0]  level_i,
  input  logic [TIMER_WIDTH-1:0]  tick_i,
  input  logic                    dir_i,
  input  logic                    cycle_i,
  input  logic [1:0]              start_cmd_i,
  input  logic                    lower_limit_pressed_i,
  input  logic                    upper_limit_pressed_i,
  input  logic [LEVEL_WIDTH-1:0]  up_step_i,
  input  logic [LEVEL_WIDTH-1:0]  max_level_i,
  input  logic [LEVEL_WIDTH-1:0]  down_step_i,
  input  logic [LEVEL_WIDTH-1:0]  low_level_i,
  input  logic [LEVEL_WIDTH-1:0]  brake_step_i,
  input  logic [TIMER_WIDTH-1:0]  full_hold_ticks_i,
  input  logic [TIMER_WIDTH-1:0]  low_hold_ticks_i,
  input  logic [TIMER_WIDTH-1:0]  rest_ticks_i,
  output mpr_pkg::phase_e         phase_o,
  output logic [LEVEL_WIDTH-1:0]  level_o,
  output logic [TIMER_WIDTH-1:0]  tick_o,
  output logic                    dir_o,
  output logic                    cycle_o,
  output logic                    limit_o
);
  import mpr_pkg::*;

  phase_e                 ph_s;
  logic [LEVEL_WIDTH-1:0] lvl_s;
  logic [TIMER_WIDTH-1:0] tick_s;
  logic                   dir_s;
  logic                   cyc_s;

  logic [LEVEL_WIDTH-1:0] up_eff;
  logic [LEVEL_WIDTH-1:0] down_eff;
  logic [LEVEL_WIDTH-1:0] brake_eff;
  logic [LEVEL_WIDTH:0]   up_sum;
  logic [TIMER_WIDTH:0]   tick_inc;
  logic [LEVEL_WIDTH-1:0] down_gap;
  logic                   limit_hit;
  logic                   moving;

  // A step of zero acts as a step of one
  assign up_eff    = (up_step_i == '0) ? LEVEL_WIDTH'(1) : up_step_i;
  assign down_eff  = (down_step_i == '0) ? LEVEL_WIDTH'(1) : down_step_i;
  assign brake_eff = (brake_step_i == '0) ? LEVEL_WIDTH'(1) : brake_step_i;

  // Take a start command only when idle; it runs its first tick right away
  always_comb begin
    ph_s   = phase_i;
    lvl_s  = level_i;
    tick_s = tick_i;
    dir_s  = dir_i;
    cyc_s  = cycle_i;
    if (phase_i == PhIdle && start_cmd_i != CmdNone) begin
      dir_s  = (start_cmd_i == CmdUp);
      cyc_s  = (start_cmd_i == CmdCycle);
      ph_s   = PhRampUp;
      lvl_s  = '0;
      tick_s = '0;
    end
  end

  assign up_sum   = {1'b0, lvl_s} + {1'b0, up_eff};
  assign tick_inc = {1'b0, tick_s} + (TIMER_WIDTH+1)'(1);
  assign down_gap = lvl_s - low_level_i;
  assign moving   = (ph_s == PhRampUp) || (ph_s == PhFull) || (ph_s == PhRampDown) ||
                    (ph_s == PhLow) || (ph_s == PhBrake);
  assign limit_hit = moving && (dir_s ? upper_limit_pressed_i : lower_limit_pressed_i);

  always_comb begin
    phase_o = ph_s;
    level_o = lvl_s;
    tick_o  = tick_s;
    dir_o   = dir_s;
    cycle_o = cyc_s;
    limit_o = 1'b0;
    if (limit_hit) begin
      limit_o = 1'b1;
      level_o = '0;
      tick_o  = '0;
      phase_o = cyc_s ? PhRest : PhIdle;
    end else begin
      case (ph_s)
        PhIdle: begin
        end
        PhRampUp: begin
          if (up_sum >= {1'b0, max_level_i}) begin
            level_o = max_level_i;
            phase_o = PhFull;
            tick_o  = '0;
          end else begin
            level_o = up_sum[LEVEL_WIDTH-1:0];
          end
        end
        PhFull: begin
          if (tick_inc >= {1'b0, full_hold_ticks_i}) begin
            phase_o = (lvl_s > low_level_i) ? PhRampDown : PhLow;
            tick_o  = '0;
          end else begin
            tick_o = tick_inc[TIMER_WIDTH-1:0];
          end
        end
        PhRampDown: begin
          // Land exactly on the low level, then hold it
          if (lvl_s > low_level_i && down_gap > down_eff) begin
            level_o = lvl_s - down_eff;
          end else begin
            if (lvl_s > low_level_i) begin
              level_o = low_level_i;
            end
            phase_o = PhLow;
            tick_o  = '0;
          end
        end
        PhLow: begin
          if (tick_inc >= {1'b0, low_hold_ticks_i}) begin
            tick_o = '0;
            if (lvl_s == '0) begin
              level_o = '0;
              phase_o = cyc_s ? PhRest : PhIdle;
            end else begin
              phase_o = PhBrake;
            end
          end else begin
            tick_o = tick_inc[TIMER_WIDTH-1:0];
          end
        end
        PhBrake: begin
          if (lvl_s > brake_eff) begin
            level_o = lvl_s - brake_eff;
          end else begin
            level_o = '0;
            tick_o  = '0;
            phase_o = cyc_s ? PhRest : PhIdle;
          end
        end
        PhRest: begin
          if (tick_inc >= {1'b0, rest_ticks_i}) begin
            tick_o  = '0;
            level_o = '0;
            // After the down half of a cycle, start the up half
            if (cyc_s && !dir_s) begin
              dir_o   = 1'b1;
              phase_o = PhRampUp;
            end else begin
              cycle_o = 1'b0;
              phase_o = PhIdle;
            end
          end else begin
            tick_o = tick_inc[TIMER_WIDTH-1:0];
          end
        end
        default: begin
          phase_o = PhIdle;
        end
      endcase
    end
  end

endmodule

[tb/sv/mpr_drive_checker.sv]
// Tick-by-tick drive profile predictor and result checker for the ramp profile block.
`timescale 1ns / 1ps

module mpr_drive_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        start_cmd_i,
  input  logic                              lower_limit_pressed_i,
  input  logic                              upper_limit_pressed_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [mpr_pkg::DefaultLevelWidth-1:0] drive_level_i,
  input  logic                              direction_up_i,
  input  logic                              busy_res_i,
  input  logic [2:0]                        phase_i,
  input  logic                              limit_stop_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [mpr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [11:0]                       cfg_data_i,
  output int                                err_count_o,
  output int                                outstanding_o
);

  import mpr_pkg::*;

  localparam int LW = DefaultLevelWidth;
  localparam int TW = DefaultTimerWidth;

  typedef struct packed {
    logic [LW-1:0] level;
    logic          up;
    logic          busy;
    logic [2:0]    ph;
    logic          lim;
  } drive_beat_t;

  // Profile settings as the block should hold them
  int up_step_q, max_level_q, down_step_q, low_level_q, brake_step_q;
  int full_hold_q, low_hold_q, rest_q;

  // Profile state
  phase_e ph_q;
  int     level_q;
  int     ticks_q;
  logic   dir_up_q;
  logic   cycle_q;

  drive_beat_t drive_expected_q[$];

  function automatic int at_least_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Cut the drive; a running full cycle goes on with a rest.
  function automatic void finish_move();
    level_q = 0;
    ticks_q = 0;
    ph_q = cycle_q ? PhRest : PhIdle;
  endfunction

  function automatic drive_beat_t advance_tick(cmd_e cmd, logic lo_sw, logic hi_sw);
    drive_beat_t beat;
    int          step;
    logic        stop;
    stop = 1'b0;
    if (ph_q == PhIdle && cmd != CmdNone) begin
      dir_up_q = (cmd == CmdUp);
      cycle_q  = (cmd == CmdCycle);
      ph_q     = PhRampUp;
      level_q  = 0;
      ticks_q  = 0;
    end
    if (ph_q >= PhRampUp && ph_q <= PhBrake && (dir_up_q ? hi_sw : lo_sw)) begin
      finish_move();
      stop = 1'b1;
    end else begin
      case (ph_q)
        PhRampUp: begin
          level_q += at_least_one(up_step_q);
          if (level_q >= max_level_q) begin
            level_q = max_level_q;
            ph_q    = PhFull;
            ticks_q = 0;
          end
        end
        PhFull: begin
          if (ticks_q + 1 >= full_hold_q) begin
            // skip the ramp down when already at or below the low level
            ph_q    = (level_q > low_level_q) ? PhRampDown : PhLow;
            ticks_q = 0;
          end else begin
            ticks_q = (ticks_q + 1) % (1 << TW);
          end
        end
        PhRampDown: begin
          step = at_least_one(down_step_q);
          if (level_q > low_level_q) begin
            level_q = (level_q - low_level_q <= step) ? low_level_q : level_q - step;
          end
          if (level_q <= low_level_q) begin
            ph_q    = PhLow;
            ticks_q = 0;
          end
        end
        PhLow: begin
          if (ticks_q + 1 >= low_hold_q) begin
            ticks_q = 0;
            if (level_q == 0) finish_move();
            else ph_q = PhBrake;
          end else begin
            ticks_q = (ticks_q + 1) % (1 << TW);
          end
        end
        PhBrake: begin
          step    = at_least_one(brake_step_q);
          level_q = (level_q > step) ? level_q - step : 0;
          if (level_q == 0) finish_move();
        end
        PhRest: begin
          if (ticks_q + 1 >= rest_q) begin
            ticks_q = 0;
            level_q = 0;
            if (cycle_q && !dir_up_q) begin
              dir_up_q = 1'b1;
              ph_q     = PhRampUp;
            end else begin
              cycle_q = 1'b0;
              ph_q    = PhIdle;
            end
          end else begin
            ticks_q = (ticks_q + 1) % (1 << TW);
          end
        end
        default: ph_q = PhIdle;
      endcase
    end
    level_q    = level_q % (1 << LW);
    beat.level = level_q[LW-1:0];
    beat.up    = dir_up_q;
    beat.busy  = (ph_q != PhIdle);
    beat.ph    = ph_q;
    beat.lim   = stop;
    return beat;
  endfunction

  function automatic void check_field(string name, logic [LW-1:0] want, logic [LW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_beat_t want;
    if (!rst_ni) begin
      up_step_q    = UpStepReset;
      max_level_q  = MaxLevelReset;
      down_step_q  = DownStepReset;
      low_level_q  = LowLevelReset;
      brake_step_q = BrakeStepReset;
      full_hold_q  = FullHoldTicksReset;
      low_hold_q   = LowHoldTicksReset;
      rest_q       = RestTicksReset;
      ph_q         = PhIdle;
      level_q      = 0;
      ticks_q      = 0;
      dir_up_q     = 1'b0;
      cycle_q      = 1'b0;
      drive_expected_q.delete();
      outstanding_o <= 0;
    end else begin
      // check first: a beat taken now cannot have its result on this edge
      if (out_valid_i && out_ready_i) begin
        if (drive_expected_q.size() == 0) begin
          $error("result beat with no tick pending");
          err_count_o++;
        end else begin
          want = drive_expected_q.pop_front();
          check_field("drive_level", want.level, drive_level_i);
          check_field("direction_up", LW'(want.up), LW'(direction_up_i));
          check_field("busy_res", LW'(want.busy), LW'(busy_res_i));
          check_field("phase", LW'(want.ph), LW'(phase_i));
          check_field("limit_stop", LW'(want.lim), LW'(limit_stop_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_expected_q.push_back(advance_tick(cmd_e'(start_cmd_i),
                                                lower_limit_pressed_i, upper_limit_pressed_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgUpStep:        up_step_q    = cfg_data_i[LW-1:0];
          CfgMaxLevel:      max_level_q  = cfg_data_i[LW-1:0];
          CfgDownStep:      down_step_q  = cfg_data_i[LW-1:0];
          CfgLowLevel:      low_level_q  = cfg_data_i[LW-1:0];
          CfgBrakeStep:     brake_step_q = cfg_data_i[LW-1:0];
          CfgFullHoldTicks: full_hold_q  = cfg_data_i[TW-1:0];
          CfgLowHoldTicks:  low_hold_q   = cfg_data_i[TW-1:0];
          CfgRestTicks:     rest_q       = cfg_data_i[TW-1:0];
          default: ;
        endcase
      end
      outstanding_o <= drive_expected_q.size();
    end
  end

  initial err_count_o = 0;

endmodule

[tb/sv/tb_motor_pwm_ramp_profile.sv]
// Stimulus, clocking and verdict for the motor PWM ramp profile block.
`timescale 1ns / 1ps

module tb_motor_pwm_ramp_profile;

  import mpr_pkg::*;

  localparam int LW          = DefaultLevelWidth;
  localparam int NumPhases   = 12;
  localparam int TicksPerSet = 127;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     tick_valid = 1'b0;
  logic                     tick_ready;
  logic [1:0]               start_cmd = CmdNone;
  logic                     lower_limit = 1'b0;
  logic                     upper_limit = 1'b0;
  logic                     drive_valid;
  logic                     drive_ready = 1'b0;
  logic [LW-1:0]            drive_level;
  logic                     direction_up;
  logic                     busy;
  logic [2:0]               phase;
  logic                     limit_stop;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = CfgUpStep;
  logic [11:0]              cfg_data = '0;

  int   err_count;
  int   outstanding;
  bit   tick_gaps = 1'b1;
  int   limit_pct = 3;
  logic [11:0] profile_regs [8];

  always #5 clk = ~clk;

  motor_pwm_ramp_profile DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (tick_valid),
    .in_ready_o            (tick_ready),
    .start_cmd_i           (start_cmd),
    .lower_limit_pressed_i (lower_limit),
    .upper_limit_pressed_i (upper_limit),
    .out_valid_o           (drive_valid),
    .out_ready_i           (drive_ready),
    .drive_level_o         (drive_level),
    .direction_up_o        (direction_up),
    .busy_res_o            (busy),
    .phase_o               (phase),
    .limit_stop_o          (limit_stop),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  mpr_drive_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (tick_valid),
    .in_ready_i            (tick_ready),
    .start_cmd_i           (start_cmd),
    .lower_limit_pressed_i (lower_limit),
    .upper_limit_pressed_i (upper_limit),
    .out_valid_i           (drive_valid),
    .out_ready_i           (drive_ready),
    .drive_level_i         (drive_level),
    .direction_up_i        (direction_up),
    .busy_res_i            (busy),
    .phase_i               (phase),
    .limit_stop_i          (limit_stop),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .err_count_o           (err_count),
    .outstanding_o         (outstanding)
  );

  // Offer one tick beat; valid stays high across back-to-back beats.
  task automatic send_tick(cmd_e cmd, logic lo_sw, logic hi_sw);
    if (tick_gaps && $urandom_range(0, 99) < 33) begin
      tick_valid <= 1'b0;
      do @(posedge clk); while (tick_gaps && $urandom_range(0, 99) < 33);
    end
    tick_valid  <= 1'b1;
    start_cmd   <= cmd;
    lower_limit <= lo_sw;
    upper_limit <= hi_sw;
    do @(posedge clk); while (!tick_ready);
  endtask

  // Drop valid and wait until every result is back.
  task automatic settle();
    tick_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_profile();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_index_e'(i);
      cfg_data  <= profile_regs[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] pick_level(int lo);
    case ($urandom_range(0, 7))
      0:       return 12'(lo);
      1:       return 12'd255;
      default: return 12'($urandom_range(lo, 255));
    endcase
  endfunction

  function automatic logic [11:0] pick_ticks();
    case ($urandom_range(0, 19))
      0, 1:    return 12'd0;
      2:       return 12'd4095;
      default: return 12'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic pick_profile(int set_no);
    if (set_no == 0) begin
      foreach (profile_regs[i]) profile_regs[i] = 12'd255;
      profile_regs[CfgFullHoldTicks] = 12'd4095;
      profile_regs[CfgLowHoldTicks]  = 12'd4095;
      profile_regs[CfgRestTicks]     = 12'd4095;
    end else if (set_no == 1) begin
      foreach (profile_regs[i]) profile_regs[i] = 12'd1;
      profile_regs[CfgLowLevel]      = 12'd0;
      profile_regs[CfgFullHoldTicks] = 12'd0;
      profile_regs[CfgLowHoldTicks]  = 12'd0;
      profile_regs[CfgRestTicks]     = 12'd0;
    end else begin
      profile_regs[CfgUpStep]        = pick_level(1);
      profile_regs[CfgMaxLevel]      = pick_level(1);
      profile_regs[CfgDownStep]      = pick_level(1);
      profile_regs[CfgLowLevel]      = pick_level(0);
      profile_regs[CfgBrakeStep]     = pick_level(1);
      profile_regs[CfgFullHoldTicks] = pick_ticks();
      profile_regs[CfgLowHoldTicks]  = pick_ticks();
      profile_regs[CfgRestTicks]     = pick_ticks();
    end
  endtask

  task automatic random_ticks(int count);
    for (int k = 0; k < count; k++) begin
      cmd_e cmd;
      cmd = ($urandom_range(0, 99) < 30) ? cmd_e'($urandom_range(1, 3)) : CmdNone;
      send_tick(cmd, $urandom_range(0, 99) < limit_pct, $urandom_range(0, 99) < limit_pct);
    end
  endtask

  // Result side: random stalls, two long hold-offs and a stretch always ready.
  initial begin : drive_sink
    int cyc;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc >= 400 && cyc < 480) || (cyc >= 5000 && cyc < 5100)) begin
        drive_ready <= 1'b0;
      end else if (cyc >= 1500 && cyc < 2500) begin
        drive_ready <= 1'b1;
      end else begin
        drive_ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset profile: a busy command is dropped, wrong-side switch is ignored,
    // then a stop on the travel-side switch and a start with the switch held.
    send_tick(CmdUp, 1'b1, 1'b0);
    send_tick(CmdDown, 1'b0, 1'b0);
    send_tick(CmdNone, 1'b0, 1'b1);
    send_tick(CmdNone, 1'b0, 1'b0);
    send_tick(CmdDown, 1'b1, 1'b0);
    settle();

    // Zero steps, zero holds and rest, low level of zero: a full cycle.
    profile_regs[CfgUpStep]        = 12'd0;
    profile_regs[CfgMaxLevel]      = 12'd2;
    profile_regs[CfgDownStep]      = 12'd0;
    profile_regs[CfgLowLevel]      = 12'd0;
    profile_regs[CfgBrakeStep]     = 12'd0;
    profile_regs[CfgFullHoldTicks] = 12'd0;
    profile_regs[CfgLowHoldTicks]  = 12'd0;
    profile_regs[CfgRestTicks]     = 12'd0;
    load_profile();
    send_tick(CmdCycle, 1'b0, 1'b0);
    repeat (14) send_tick(CmdNone, 1'b0, 1'b0);
    settle();

    // Max below low: no ramp down, hold then brake.
    profile_regs[CfgUpStep]        = 12'd255;
    profile_regs[CfgMaxLevel]      = 12'd3;
    profile_regs[CfgLowLevel]      = 12'd200;
    profile_regs[CfgFullHoldTicks] = 12'd1;
    profile_regs[CfgLowHoldTicks]  = 12'd2;
    load_profile();
    send_tick(CmdUp, 1'b0, 1'b0);
    repeat (6) send_tick(CmdNone, 1'b0, 1'b0);
    settle();

    for (int set_no = 0; set_no < NumPhases; set_no++) begin
      pick_profile(set_no);
      load_profile();
      tick_gaps = (set_no != 5);
      limit_pct = (set_no == 9) ? 40 : 3;
      random_ticks(TicksPerSet);
      settle();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mpr_pkg.sv
hw/rtl/mpr_step.sv
hw/rtl/motor_pwm_ramp_profile.sv
tb/sv/mpr_drive_checker.sv
tb/sv/tb_motor_pwm_ramp_profile.sv
